### hdl/fxp_alu_pkg.sv
// Package: shared constants, opcodes and types for the Q24.8 fixed-point unit.
`default_nettype none
package fxp_alu_pkg;
   localparam int FRACTION_BITS_DEF = 8;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FUNC_W = 4;

   typedef enum logic [FUNC_W-1:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
      OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
      OP_MIN = 4'd12, OP_MAX = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
   } op_type;
endpackage
`default_nettype wire

### hdl/fxp_alu_front.sv
// Front end: input register slice that decodes the operation and registers operands.
`default_nettype none
module fxp_alu_front #(
   parameter int DW = fxp_alu_pkg::DATA_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic in_ready,
   input  wire logic [fxp_alu_pkg::FUNC_W-1:0] in_func,
   input  wire logic [DW-1:0] in_a,
   input  wire logic [DW-1:0] in_b,
   output logic out_valid,
   input  wire logic out_ready,
   output fxp_alu_pkg::op_type out_func,
   output logic [DW-1:0] out_a,
   output logic [DW-1:0] out_b
);
   logic valid_ff;
   fxp_alu_pkg::op_type func_ff;
   logic [DW-1:0] a_ff, b_ff;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_func = func_ff;
   assign out_a = a_ff;
   assign out_b = b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         func_ff <= fxp_alu_pkg::op_type'(in_func);
         a_ff <= in_a;
         b_ff <= in_b;
      end
   end
endmodule
`default_nettype wire

### hdl/fxp_alu_back.sv
// Back end: pipelined execution with a restoring divider, one stage per quotient bit.
`default_nettype none
module fxp_alu_back #(
   parameter int DW = fxp_alu_pkg::DATA_WIDTH_DEF,
   parameter int FB = fxp_alu_pkg::FRACTION_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic in_ready,
   input  wire fxp_alu_pkg::op_type in_func,
   input  wire logic [DW-1:0] in_a,
   input  wire logic [DW-1:0] in_b,
   output logic out_valid,
   input  wire logic out_ready,
   output logic [DW-1:0] out_result,
   output logic out_cmp,
   output logic out_dz,
   output logic out_ovf
);
   localparam int NW = DW + FB;       // dividend magnitude width
   localparam int NS = NW + 2;        // stages: entry, NW divide steps, finish
   localparam int MW = 2 * DW;
   localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

   logic adv;
   logic [NS-1:0] v_ff;
   fxp_alu_pkg::op_type f_ff [NS];
   logic [DW-1:0] r_ff [NS];
   logic c_ff [NS], z_ff [NS], o_ff [NS], n_ff [NS];
   logic [NW-1:0] q_ff [NS];
   logic [DW:0] rm_ff [NS];
   logic [DW-1:0] d_ff [NS];
   logic [MW-1:0] p_ff [NS];

   assign adv = !v_ff[NS-1] || out_ready;
   assign in_ready = adv;
   assign out_valid = v_ff[NS-1];
   assign out_result = r_ff[NS-1];
   assign out_cmp = c_ff[NS-1];
   assign out_dz = z_ff[NS-1];
   assign out_ovf = o_ff[NS-1];

   function automatic logic [DW:0] absx(input logic [DW-1:0] v);
      return v[DW-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
   endfunction

   function automatic logic [DW-1:0] sat(input logic neg, input logic [MW:0] m,
                                         output logic ov);
      ov = 1'b0;
      if (!neg) begin
         if (m > {{(MW+1-DW){1'b0}}, MAXV}) begin
            ov = 1'b1;
            return MAXV;
         end
         return m[DW-1:0];
      end
      if (m > {{(MW+1-DW){1'b0}}, MINV}) begin
         ov = 1'b1;
         return MINV;
      end
      return ~m[DW-1:0] + 1'b1;
   endfunction

   // stage 0: everything except multiply and divide resolves here
   logic [DW:0] s0_am, s0_bm;
   logic [DW-1:0] s0_r, s0_sum, s0_opb;
   logic s0_c, s0_z, s0_o, s0_lt, s0_sub, s0_neg, s0_tmp;
   always_comb begin
      s0_am = absx(in_a);
      s0_bm = absx(in_b);
      s0_r = '0;
      s0_c = 1'b0;
      s0_z = 1'b0;
      s0_o = 1'b0;
      s0_tmp = 1'b0;
      s0_neg = in_a[DW-1] ^ in_b[DW-1];
      s0_lt = $signed(in_a) < $signed(in_b);
      s0_sub = (in_func == fxp_alu_pkg::OP_SUB) || (in_func == fxp_alu_pkg::OP_DEC);
      s0_opb = ((in_func == fxp_alu_pkg::OP_INC) || (in_func == fxp_alu_pkg::OP_DEC))
               ? {{(DW-1){1'b0}}, 1'b1} : in_b;
      s0_sum = s0_sub ? in_a - s0_opb : in_a + s0_opb;
      unique case (in_func)
         fxp_alu_pkg::OP_ADD, fxp_alu_pkg::OP_SUB,
         fxp_alu_pkg::OP_INC, fxp_alu_pkg::OP_DEC: begin
            if (((s0_sub ? (in_a[DW-1] != s0_opb[DW-1]) : (in_a[DW-1] == s0_opb[DW-1])))
                && (s0_sum[DW-1] != in_a[DW-1])) begin
               s0_o = 1'b1;
               s0_r = in_a[DW-1] ? MINV : MAXV;
            end else begin
               s0_r = s0_sum;
            end
         end
         fxp_alu_pkg::OP_DIV: s0_z = (in_b == '0);
         fxp_alu_pkg::OP_GT: s0_c = $signed(in_b) < $signed(in_a);
         fxp_alu_pkg::OP_LT: s0_c = s0_lt;
         fxp_alu_pkg::OP_GE: s0_c = !s0_lt;
         fxp_alu_pkg::OP_LE: s0_c = !($signed(in_b) < $signed(in_a));
         fxp_alu_pkg::OP_EQ: s0_c = (in_a == in_b);
         fxp_alu_pkg::OP_NE: s0_c = (in_a != in_b);
         fxp_alu_pkg::OP_MIN: s0_r = s0_lt ? in_a : in_b;
         fxp_alu_pkg::OP_MAX: s0_r = s0_lt ? in_b : in_a;
         fxp_alu_pkg::OP_TOINT: s0_r = sat(in_a[DW-1],
            {{(MW-DW+FB){1'b0}}, s0_am[DW:FB]}, s0_tmp);
         fxp_alu_pkg::OP_FROMINT: s0_r = sat(in_a[DW-1],
            {{(MW-DW-FB){1'b0}}, s0_am, {FB{1'b0}}}, s0_o);
         default: s0_r = '0;
      endcase
      if (in_func == fxp_alu_pkg::OP_DIV || in_func == fxp_alu_pkg::OP_MUL) begin
         s0_neg = in_a[DW-1] ^ in_b[DW-1];
      end else begin
         s0_neg = s0_tmp & 1'b0;
      end
   end

   // divider steps and final rounding of multiply and divide results
   logic [DW+1:0] st_t [NW];
   logic [MW:0] fin_m;
   logic [DW:0] fin_d, fin_dr;
   logic fin_up, fin_o;
   logic [DW-1:0] fin_r;
   always_comb begin
      for (int i = 0; i < NW; i++) begin
         st_t[i] = {rm_ff[i], q_ff[i][NW-1]} - {2'b0, d_ff[i]};
      end
      fin_d = {1'b0, d_ff[NS-2]};
      fin_dr = fin_d - rm_ff[NS-2];
      fin_up = n_ff[NS-2] ? (rm_ff[NS-2] > fin_dr) : (rm_ff[NS-2] >= fin_dr);
      fin_m = {{(MW+1-NW){1'b0}}, q_ff[NS-2]} + {{MW{1'b0}}, fin_up};
      if (f_ff[NS-2] == fxp_alu_pkg::OP_MUL) begin
         fin_m = {{(FB+1){1'b0}}, p_ff[NS-2][MW-1:FB]}
               + {{MW{1'b0}}, (p_ff[NS-2][FB-1:0] > {FB{1'b0}}) &&
                  (n_ff[NS-2] ? (p_ff[NS-2][FB-1:0] > {1'b1, {(FB-1){1'b0}}})
                              : p_ff[NS-2][FB-1])};
      end
      fin_r = sat(n_ff[NS-2], fin_m, fin_o);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
      if (adv) begin
         f_ff[0] <= in_func;
         r_ff[0] <= s0_r;
         c_ff[0] <= s0_c;
         z_ff[0] <= s0_z;
         o_ff[0] <= s0_o;
         n_ff[0] <= s0_neg;
         q_ff[0] <= {s0_am[DW-1:0], {FB{1'b0}}};
         rm_ff[0] <= '0;
         d_ff[0] <= s0_bm[DW-1:0];
         p_ff[0] <= s0_am[DW-1:0] * s0_bm[DW-1:0];
         for (int i = 1; i < NS; i++) begin
            f_ff[i] <= f_ff[i-1];
            c_ff[i] <= c_ff[i-1];
            z_ff[i] <= z_ff[i-1];
            n_ff[i] <= n_ff[i-1];
            d_ff[i] <= d_ff[i-1];
            p_ff[i] <= p_ff[i-1];
         end
         for (int i = 1; i < NS - 1; i++) begin
            r_ff[i] <= r_ff[i-1];
            o_ff[i] <= o_ff[i-1];
            if (!st_t[i-1][DW+1]) begin
               rm_ff[i] <= st_t[i-1][DW:0];
               q_ff[i] <= {q_ff[i-1][NW-2:0], 1'b1};
            end else begin
               rm_ff[i] <= {rm_ff[i-1][DW-1:0], q_ff[i-1][NW-1]};
               q_ff[i] <= {q_ff[i-1][NW-2:0], 1'b0};
            end
         end
         rm_ff[NS-1] <= rm_ff[NS-2];
         q_ff[NS-1] <= q_ff[NS-2];
         if ((f_ff[NS-2] == fxp_alu_pkg::OP_MUL)
             || (f_ff[NS-2] == fxp_alu_pkg::OP_DIV && !z_ff[NS-2])) begin
            r_ff[NS-1] <= fin_r;
            o_ff[NS-1] <= fin_o;
         end else begin
            r_ff[NS-1] <= r_ff[NS-2];
            o_ff[NS-1] <= o_ff[NS-2];
         end
      end
   end

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_dz |-> out_result == '0 && !out_ovf);
   a_cmp_flags: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_cmp |-> out_result == '0 && !out_dz);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_result));
endmodule
`default_nettype wire

### hdl/fixed_point_q24_8_alu_core.sv
// Top level: Q24.8 fixed-point arithmetic unit with stream ports.
// Pipeline: a front register, then the back pipe's entry, divide-step and finish stages.
// Throughput: one word per cycle when not stalled; divider unrolled one quotient bit per stage.
// The multiply is registered at entry and rounded in the final stage.
// Reset: synchronous, active high; clears all valid bits, no results held.
`default_nettype none
module fixed_point_q24_8_alu_core #(
   parameter int FRACTION_BITS = fxp_alu_pkg::FRACTION_BITS_DEF,
   parameter int DATA_WIDTH = fxp_alu_pkg::DATA_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [2*DATA_WIDTH+7:0] req_tdata, // func[3:0], operand_a, operand_b, pad
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [DATA_WIDTH+7:0] rsp_tdata // result, compare_true, divide_by_zero, overflow, pad
);
   fxp_alu_pkg::op_type q_func;
   logic q_valid, q_ready;
   logic [DATA_WIDTH-1:0] q_a, q_b, res;
   logic cmp, dz, ovf;

   fxp_alu_front #(.DW(DATA_WIDTH)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_func(req_tdata[3:0]),
      .in_a(req_tdata[DATA_WIDTH+3:4]),
      .in_b(req_tdata[2*DATA_WIDTH+3:DATA_WIDTH+4]),
      .out_valid(q_valid), .out_ready(q_ready),
      .out_func(q_func), .out_a(q_a), .out_b(q_b)
   );

   fxp_alu_back #(.DW(DATA_WIDTH), .FB(FRACTION_BITS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready),
      .in_func(q_func), .in_a(q_a), .in_b(q_b),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_result(res), .out_cmp(cmp), .out_dz(dz), .out_ovf(ovf)
   );

   assign rsp_tdata = {5'b0, ovf, dz, cmp, res};
endmodule
`default_nettype wire
